### src/pidaf_pkg.sv
// Package for the PID block with asymmetric integral and filtered derivative.
// Holds the word types, sequencer states, register indexes and Q16.16 helpers.
// No dependencies.
package pidaf_pkg;

	localparam logic signed [32:0] ERR_LIMIT  = 33'sd262144;
	localparam logic [20:0]        DT_DEFAULT = 21'd66;
	localparam logic signed [32:0] FILT_KEEP  = 33'sd52429;
	localparam logic signed [32:0] FILT_NEW   = 33'sd13107;
	localparam logic [5:0]         DIV_STEPS  = 6'd49;

	typedef enum logic [3:0] {
		REG_GAIN_PROP   = 4'd0,
		REG_GAIN_INTEG  = 4'd1,
		REG_GAIN_DERIV  = 4'd2,
		REG_INTEG_UPPER = 4'd3,
		REG_INTEG_LOWER = 4'd4,
		REG_DRIVE_UPPER = 4'd5,
		REG_DRIVE_LOWER = 4'd6,
		REG_TARGET      = 4'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_IMUL,
		ST_IRND,
		ST_IACC,
		ST_PRND,
		ST_IRND2,
		ST_DWAIT,
		ST_FMUL1,
		ST_FMUL2,
		ST_FADD,
		ST_FRND,
		ST_DMUL,
		ST_DRND,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic signed [31:0] measurement;
		logic [20:0]        step_time;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic signed [31:0] raw_drive;
		logic signed [31:0] loop_error;
	} result_t;

	typedef struct packed {
		logic               en;
		logic signed [32:0] a;
		logic signed [32:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        start;
		logic [48:0] dividend;
		logic [20:0] divisor;
	} div_req_t;

	function automatic logic signed [63:0] sx64(input logic signed [31:0] x);
		return $signed({{32{x[31]}}, x});
	endfunction

	function automatic logic signed [32:0] sx33(input logic signed [31:0] x);
		return $signed({x[31], x});
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	// round half up from Q32.32 to Q16.16, saturated
	function automatic logic signed [31:0] round16(input logic signed [63:0] x);
		logic signed [63:0] t;
		t = (x + 64'sd32768) >>> 16;
		return sat32(t);
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [31:0] x,
		input logic signed [31:0] lo, input logic signed [31:0] hi);
		if (x < lo) begin
			return lo;
		end else if (x > hi) begin
			return hi;
		end
		return x;
	endfunction

endpackage

### src/pidaf_mul.sv
// Shared signed 33 x 33 multiplier with a registered product.
// Depends on pidaf_pkg.
module pidaf_mul (
	input  logic                clk,
	input  pidaf_pkg::mul_req_t req,
	output logic signed [63:0]  prod
);
	import pidaf_pkg::*;

	logic signed [63:0] full;
	logic signed [63:0] prod_q;

	assign full = req.a * req.b;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= full;
		end
	end

	assign prod = prod_q;

endmodule

### src/pidaf_div.sv
// Restoring divider, one quotient bit per cycle, 49-bit dividend by 21-bit divisor.
// Depends on pidaf_pkg.
module pidaf_div (
	input  logic                clk,
	input  logic                arst_n,
	input  pidaf_pkg::div_req_t req,
	output logic                busy,
	output logic [48:0]         quotient
);
	import pidaf_pkg::*;

	logic [5:0]  cnt_q;
	logic [48:0] n_q;
	logic [20:0] rem_q;
	logic [20:0] dvs_q;
	logic [21:0] trial;
	logic [20:0] diffv;
	logic        ge;

	assign trial = {rem_q, n_q[48]};
	assign diffv = trial[20:0] - dvs_q;
	assign ge    = trial >= {1'b0, dvs_q};
	assign busy  = cnt_q != 6'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (req.start) begin
			cnt_q <= DIV_STEPS;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q   <= req.dividend;
			rem_q <= 21'd0;
			dvs_q <= req.divisor;
		end else if (busy) begin
			rem_q <= ge ? diffv : trial[20:0];
			n_q   <= {n_q[47:0], ge};
		end
	end

	assign quotient = n_q;

endmodule

### src/pid_asymmetric_integral_filtered_d.sv
// Top level: PID controller, derivative on measurement, asymmetric integral.
// Holds the configuration registers, the sequencer and the loop state.
// Depends on pidaf_pkg, pidaf_mul and pidaf_div.
//
//   channel  handshake             word
//   sample   sample_valid/stall    measurement, step_time
//   result   result_valid/stall    drive, raw_drive, loop_error
//   cfg      cfg_valid/ready       cfg_index, cfg_data
//
// A new word is accepted only after the result of the last one is loaded; the
// 49-step bit-serial divider for the derivative is the longest part of the sequence,
// and the shared multiplier runs six products in sequence around it.
// sample_stall is high from acceptance until the result is loaded.
// A result waiting under result_stall holds the sequencer in its last step.
// Reset clears the registers, the integral, the filter and the last measurement.
module pid_asymmetric_integral_filtered_d (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  pidaf_pkg::sample_t sample,
	output logic               result_valid,
	input  logic               result_stall,
	output pidaf_pkg::result_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import pidaf_pkg::*;

	state_t state_q, state_d;

	logic [30:0]        gain_prop_q, gain_integ_q, gain_deriv_q;
	logic signed [31:0] integ_upper_q, integ_lower_q, drive_upper_q, drive_lower_q;
	logic signed [31:0] target_q;

	logic signed [31:0] integ_q, dfilt_q, last_q;
	logic signed [31:0] meas_q, err_q, rnd_q, p_q, i_q, d_q, deriv_q, raw_q;
	logic signed [32:0] err_w_q;
	logic [20:0]        dt_q;
	logic signed [63:0] fsum_q;
	logic               div_neg_q;
	result_t            res_q;
	logic               res_valid_q;

	mul_req_t           mul_req;
	logic signed [63:0] prod;
	div_req_t           div_req;
	logic               div_busy;
	logic [48:0]        quot;

	logic signed [32:0] err_w_c, diff_c;
	logic [32:0]        mag_c;
	logic signed [63:0] pw_c;
	logic signed [31:0] isum_c, deriv_c, rterm_c;
	logic               in_win_c, accept, res_load;

	pidaf_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	pidaf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.busy     (div_busy),
		.quotient (quot)
	);

	assign cfg_ready    = 1'b1;
	assign sample_stall = state_q != ST_IDLE;
	assign accept       = sample_valid && !sample_stall;
	assign res_load     = (state_q == ST_OUT) && (!res_valid_q || !result_stall);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign err_w_c  = sx33(target_q) - sx33(meas_q);
	assign diff_c   = sx33(meas_q) - sx33(last_q);
	assign mag_c    = diff_c[32] ? 33'(-diff_c) : 33'(diff_c);
	assign pw_c     = (err_w_q <= 33'sd0) ? (prod <<< 1) : prod;
	assign in_win_c = (err_w_q < ERR_LIMIT) && (err_w_q > -ERR_LIMIT);
	assign isum_c   = in_win_c ? sat32(sx64(integ_q) + sx64(rnd_q)) : integ_q;
	assign rterm_c  = round16(prod);

	always_comb begin
		if (!div_neg_q) begin
			deriv_c = (quot > 49'd2147483647) ? 32'sh7fffffff : $signed(quot[31:0]);
		end else begin
			deriv_c = (quot > 49'd2147483648) ? 32'sh80000000 : $signed(-quot[31:0]);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_d = ST_ERR;
			ST_ERR:   state_d = ST_IMUL;
			ST_IMUL:  state_d = ST_IRND;
			ST_IRND:  state_d = ST_IACC;
			ST_IACC:  state_d = ST_PRND;
			ST_PRND:  state_d = ST_IRND2;
			ST_IRND2: state_d = ST_DWAIT;
			ST_DWAIT: if (!div_busy) state_d = ST_FMUL1;
			ST_FMUL1: state_d = ST_FMUL2;
			ST_FMUL2: state_d = ST_FADD;
			ST_FADD:  state_d = ST_FRND;
			ST_FRND:  state_d = ST_DMUL;
			ST_DMUL:  state_d = ST_DRND;
			ST_DRND:  state_d = ST_SUM;
			ST_SUM:   state_d = ST_OUT;
			ST_OUT:   if (res_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mul_req          = '0;
		div_req.start    = state_q == ST_ERR;
		div_req.dividend = {mag_c, 16'd0};
		div_req.divisor  = dt_q;
		case (state_q)
			ST_IMUL: begin
				mul_req = '{en: 1'b1, a: err_w_q, b: $signed({12'd0, dt_q})};
			end
			ST_IACC: begin
				mul_req = '{en: 1'b1, a: sx33(err_q), b: $signed({2'd0, gain_prop_q})};
			end
			ST_PRND: begin
				mul_req = '{en: 1'b1, a: sx33(integ_q), b: $signed({2'd0, gain_integ_q})};
			end
			ST_FMUL1: begin
				mul_req = '{en: 1'b1, a: sx33(dfilt_q), b: FILT_KEEP};
			end
			ST_FMUL2: begin
				mul_req = '{en: 1'b1, a: sx33(deriv_q), b: FILT_NEW};
			end
			ST_DMUL: begin
				mul_req = '{en: 1'b1, a: sx33(dfilt_q), b: $signed({2'd0, gain_deriv_q})};
			end
			default: begin
				mul_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			res_valid_q   <= 1'b0;
			gain_prop_q   <= '0;
			gain_integ_q  <= '0;
			gain_deriv_q  <= '0;
			integ_upper_q <= '0;
			integ_lower_q <= '0;
			drive_upper_q <= '0;
			drive_lower_q <= '0;
			target_q      <= '0;
			integ_q       <= '0;
			dfilt_q       <= '0;
			last_q        <= '0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GAIN_PROP:   gain_prop_q   <= cfg_data[30:0];
					REG_GAIN_INTEG:  gain_integ_q  <= cfg_data[30:0];
					REG_GAIN_DERIV:  gain_deriv_q  <= cfg_data[30:0];
					REG_INTEG_UPPER: integ_upper_q <= cfg_data;
					REG_INTEG_LOWER: integ_lower_q <= cfg_data;
					REG_DRIVE_UPPER: drive_upper_q <= cfg_data;
					REG_DRIVE_LOWER: drive_lower_q <= cfg_data;
					REG_TARGET:      target_q      <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_IACC) begin
				integ_q <= clamp32(isum_c, integ_lower_q, integ_upper_q);
			end
			if (state_q == ST_FRND) begin
				dfilt_q <= round16(fsum_q);
			end
			if (res_load) begin
				last_q <= meas_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meas_q <= sample.measurement;
			dt_q   <= (sample.step_time == 21'd0) ? DT_DEFAULT : sample.step_time;
		end
		case (state_q)
			ST_ERR: begin
				err_w_q   <= err_w_c;
				err_q     <= sat32($signed({{31{err_w_c[32]}}, err_w_c}));
				div_neg_q <= diff_c[32];
			end
			ST_IRND:  rnd_q <= round16(pw_c);
			ST_PRND:  p_q <= rterm_c;
			ST_IRND2: i_q <= rterm_c;
			ST_DWAIT: if (!div_busy) deriv_q <= deriv_c;
			ST_FMUL2: fsum_q <= prod;
			ST_FADD:  fsum_q <= fsum_q + prod;
			ST_DRND:  d_q <= sat32(-sx64(rterm_c));
			ST_SUM:   raw_q <= sat32(sx64(p_q) + sx64(i_q) + sx64(d_q));
			ST_OUT: begin
				if (res_load) begin
					res_q.drive      <= clamp32(raw_q, drive_lower_q, drive_upper_q);
					res_q.raw_drive  <= raw_q;
					res_q.loop_error <= err_q;
				end
			end
			default: ;
		endcase
	end

	a_idle_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_busy)
		else $error("divider busy while sequencer idle");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_ERR))
		else $error("accepted word did not start the sequence");

	a_div_started: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ERR) |=> div_busy)
		else $error("divider not started for derivative");

	a_result_only_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> ($past(state_q) == ST_OUT))
		else $error("result raised outside final step");

endmodule
